### hdl/bpk_pkg.sv
// Shared types and constants for the MSB-first bit packer.
`timescale 1ns / 1ps

package bpk_pkg;

    localparam int DATA_W             = 32;
    localparam int LEN_W              = 6;
    localparam int BYTE_W             = 8;
    localparam int MAX_FIELD_BITS_DEF = 32;

    // Input op codes; the fourth code is unused and the item is dropped.
    localparam logic [1:0] OP_APPEND  = 2'd0;
    localparam logic [1:0] OP_PAD     = 2'd1;
    localparam logic [1:0] OP_DISCARD = 2'd2;

    // Bit window in the back end: up to 7 held bits plus a 32-bit field.
    localparam int WIN_W   = DATA_W + BYTE_W;
    localparam int TOT_W   = 6;
    localparam int HELD_W  = BYTE_W - 1;
    localparam int HCNT_W  = 3;

    // Command queue between front and back.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [1:0]        op;
        logic [DATA_W-1:0] data;
        logic [LEN_W-1:0]  bit_len;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_byte;
    } out_item_t;

    typedef enum logic [1:0] {
        CMD_APPEND,
        CMD_PAD,
        CMD_DISCARD
    } cmd_kind_t;

    // Field is stored left aligned: its first bit sits in bit DATA_W-1.
    typedef struct packed {
        cmd_kind_t         kind;
        logic [DATA_W-1:0] field_left;
        logic [LEN_W-1:0]  len;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

### hdl/msb_first_bit_packer.sv
// Top level of the MSB-first variable-length bit packer.
`timescale 1ns / 1ps

// Packs fields of 0 to 32 bits into a byte stream, earliest bit in bit 7 of
// each byte. Op append masks data to bit_len (saturated to MAX_FIELD_BITS and
// to 32) and emits every byte it completes; op pad flushes any leftover bits
// as one byte padded with zeros on the right; op discard drops the leftover;
// the unused op code is accepted and ignored. last_byte marks the final byte
// of each item. The front end takes one input transfer per cycle into a
// two-entry command queue, so s_ready only drops when that queue is full.
// The back end is the bottleneck: it first loads a command into its bit
// window and then emits the bytes it completes; an append completes 0 to 4
// bytes, a pad emits one byte only if bits are held, and a discard emits
// none. Bytes leave through a registered output stage. While a byte waits
// for m_ready the emitter stalls; it can still load the next command when
// it holds no complete byte.
module msb_first_bit_packer #(
    parameter int MAX_FIELD_BITS = bpk_pkg::MAX_FIELD_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bpk_pkg::in_item_t   s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output bpk_pkg::out_item_t  m_payload
);

    bpk_pkg::q_status_t q_status;
    bpk_pkg::cmd_t      push_cmd;
    bpk_pkg::cmd_t      pop_cmd;
    logic               push;
    logic               pop;

    // Classify input transfers and left align the field.
    bpk_front #(
        .MAX_FIELD_BITS(MAX_FIELD_BITS)
    ) u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .q_status  (q_status),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    // Decouple the front from the byte emitter.
    bpk_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .q_status (q_status)
    );

    // Hold the leftover bits and emit one byte per cycle while the output is not stalled.
    bpk_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_status  (q_status),
        .pop_cmd   (pop_cmd),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

### hdl/bpk_front.sv
// Front end: accepts input transfers, classifies them and builds commands.
`timescale 1ns / 1ps

module bpk_front #(
    parameter int MAX_FIELD_BITS = bpk_pkg::MAX_FIELD_BITS_DEF
) (
    input  logic                s_valid,
    output logic                s_ready,
    input  bpk_pkg::in_item_t   s_payload,
    input  bpk_pkg::q_status_t  q_status,
    output logic                push,
    output bpk_pkg::cmd_t       push_cmd
);

    localparam int CAP = (MAX_FIELD_BITS < bpk_pkg::DATA_W) ? MAX_FIELD_BITS
                                                            : bpk_pkg::DATA_W;
    localparam logic [bpk_pkg::LEN_W-1:0] CAP_LEN = bpk_pkg::LEN_W'(CAP);
    localparam logic [bpk_pkg::LEN_W-1:0] DATA_LEN = bpk_pkg::LEN_W'(bpk_pkg::DATA_W);

    logic [bpk_pkg::LEN_W-1:0] len_eff;
    logic [bpk_pkg::LEN_W-1:0] shift_amt;
    logic                      known_op;

    assign s_ready = !q_status.full;

    // Saturate the length, then left align: the shift drops the bits above len.
    assign len_eff   = (s_payload.bit_len > CAP_LEN) ? CAP_LEN : s_payload.bit_len;
    assign shift_amt = DATA_LEN - len_eff;

    always_comb begin
        push_cmd.field_left = s_payload.data << shift_amt;
        push_cmd.len        = len_eff;
        known_op            = 1'b1;
        case (s_payload.op)
            bpk_pkg::OP_APPEND:  push_cmd.kind = bpk_pkg::CMD_APPEND;
            bpk_pkg::OP_PAD:     push_cmd.kind = bpk_pkg::CMD_PAD;
            bpk_pkg::OP_DISCARD: push_cmd.kind = bpk_pkg::CMD_DISCARD;
            default: begin
                push_cmd.kind = bpk_pkg::CMD_DISCARD;
                known_op      = 1'b0;
            end
        endcase
    end

    // Drop the unused op code: accepted, never queued.
    assign push = s_valid && s_ready && known_op;

endmodule

### hdl/bpk_queue.sv
// Short command queue between the front and back ends.
`timescale 1ns / 1ps

module bpk_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  bpk_pkg::cmd_t       push_cmd,
    input  logic                pop,
    output bpk_pkg::cmd_t       pop_cmd,
    output bpk_pkg::q_status_t  q_status
);

    bpk_pkg::cmd_t                    entry_reg [bpk_pkg::QDEPTH];
    logic [bpk_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [bpk_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [bpk_pkg::QCNT_W-1:0]       count_reg, count_next;

    localparam logic [bpk_pkg::QCNT_W-1:0] FULL_CNT = bpk_pkg::QCNT_W'(bpk_pkg::QDEPTH);
    localparam logic [bpk_pkg::QPTR_W-1:0] LAST_PTR =
        bpk_pkg::QPTR_W'(bpk_pkg::QDEPTH - 1);

    assign q_status.full  = (count_reg == FULL_CNT);
    assign q_status.empty = (count_reg == '0);
    assign pop_cmd        = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### hdl/bpk_back.sv
// Back end: merges commands into the bit window and emits bytes.
`timescale 1ns / 1ps

module bpk_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  bpk_pkg::q_status_t  q_status,
    input  bpk_pkg::cmd_t       pop_cmd,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output bpk_pkg::out_item_t  m_payload
);

    // Window is left aligned; total counts its live bits. Below 8, the top
    // bits are the held leftover with zeros beneath.
    logic [bpk_pkg::WIN_W-1:0]  win_reg, win_next;
    logic [bpk_pkg::TOT_W-1:0]  total_reg, total_next;
    logic                       m_valid_reg, m_valid_next;
    bpk_pkg::out_item_t         m_item_reg, m_item_next;

    logic [bpk_pkg::HELD_W-1:0] held_left;
    logic [bpk_pkg::HCNT_W-1:0] held_count;
    logic                       have_byte;
    logic                       slot_free;
    logic                       emit;

    localparam logic [bpk_pkg::TOT_W-1:0] BYTE_TOT = bpk_pkg::TOT_W'(bpk_pkg::BYTE_W);

    assign held_left  = win_reg[bpk_pkg::WIN_W-1 -: bpk_pkg::HELD_W];
    assign held_count = total_reg[bpk_pkg::HCNT_W-1:0];
    assign have_byte  = (total_reg[bpk_pkg::TOT_W-1:bpk_pkg::HCNT_W] != '0);
    assign slot_free  = !m_valid_reg || m_ready;
    assign emit       = have_byte && slot_free;
    assign pop        = !have_byte && !q_status.empty;

    always_comb begin
        win_next     = win_reg;
        total_next   = total_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_item_next  = m_item_reg;
        if (emit) begin
            m_valid_next          = 1'b1;
            m_item_next.out_byte  = win_reg[bpk_pkg::WIN_W-1 -: bpk_pkg::BYTE_W];
            m_item_next.last_byte = (total_reg < (BYTE_TOT + BYTE_TOT));
            win_next              = win_reg << bpk_pkg::BYTE_W;
            total_next            = total_reg - BYTE_TOT;
        end else if (pop) begin
            case (pop_cmd.kind)
                bpk_pkg::CMD_APPEND: begin
                    win_next   = {held_left, {(bpk_pkg::WIN_W - bpk_pkg::HELD_W){1'b0}}}
                               | ({pop_cmd.field_left, {bpk_pkg::BYTE_W{1'b0}}}
                                  >> held_count);
                    total_next = bpk_pkg::TOT_W'(held_count) + pop_cmd.len;
                end
                bpk_pkg::CMD_PAD: begin
                    // Leftover becomes one zero-padded byte, if there is any.
                    total_next = (held_count != '0) ? BYTE_TOT : '0;
                end
                default: begin
                    win_next   = '0;
                    total_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg     <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            win_reg     <= win_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
        m_item_reg <= m_item_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_item_reg;

endmodule

### hdl/bpk_checker.sv
// Port-level checker for the bit packer, bound to the top level.
`timescale 1ns / 1ps

module bpk_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input bpk_pkg::out_item_t m_payload
);

    // Reset empties the queue and the output stage.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && s_ready))
        else $error("outputs not idle after reset");

    // Bytes of one item follow back to back once the previous one is taken.
    a_burst_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_payload.last_byte) |=> m_valid)
        else $error("gap inside the bytes of one item");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_payload)))
        else $error("stalled result changed or dropped");

    // Hold the last marker low while a non-final byte is stalled.
    a_stall_no_last_change: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready && !m_payload.last_byte) |=> !m_payload.last_byte)
        else $error("last marker changed while stalled");

endmodule

bind msb_first_bit_packer bpk_checker u_bpk_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);
